[rtl/rgbrd_pkg.sv]
`timescale 1ns / 1ps

package rgbrd_pkg;

   localparam int unsigned LenWidth = 14;
   localparam int unsigned CntWidth = 13;
   localparam int unsigned ErrWidth = 10;
   localparam logic [LenWidth-1:0] LenMax = 14'd8192;

   typedef enum logic [1:0] {
      CSR_LINE_WIDTH = 2'd0,
      CSR_LINE_COUNT = 2'd1
   } csr_index_type;

   typedef struct packed {
      logic [2:0]          level;
      logic [ErrWidth-1:0] error;
   } chan_type;

   // sum of error and sample, 11 bit signed so any error pattern fits
   function automatic logic signed [10:0] err_sum(logic [ErrWidth-1:0] err,
                                                  logic [7:0] sample);
      err_sum = signed'({err[ErrWidth-1], err}) + signed'({3'b000, sample});
   endfunction

   // red and blue: 3 bit level, expansion {l, l, l >> 1}
   function automatic chan_type quant_rb(logic [ErrWidth-1:0] err, logic [7:0] sample);
      logic signed [10:0] acc;
      logic [2:0]         lvl;
      logic [7:0]         expd;
      logic [10:0]        diff;
      chan_type           res;
      acc = err_sum(err, sample);
      if (acc < 11'sd0) begin
         lvl = 3'd0;
      end else if (acc > 11'sd255) begin
         lvl = 3'd7;
      end else begin
         lvl = acc[7:5];
      end
      expd = {lvl, lvl, lvl[2:1]};
      diff = acc - signed'({3'b000, expd});
      res.level = lvl;
      res.error = diff[ErrWidth-1:0];
      return res;
   endfunction

   // green: 2 bit level, expansion g * 85
   function automatic chan_type quant_g(logic [ErrWidth-1:0] err, logic [7:0] sample);
      logic signed [10:0] acc;
      logic [1:0]         lvl;
      logic [7:0]         expd;
      logic [10:0]        diff;
      chan_type           res;
      acc = err_sum(err, sample);
      if (acc < 11'sd0) begin
         lvl = 2'd0;
      end else if (acc > 11'sd255) begin
         lvl = 2'd3;
      end else begin
         lvl = acc[7:6];
      end
      expd = {lvl, lvl, lvl, lvl};
      diff = acc - signed'({3'b000, expd});
      res.level = {1'b0, lvl};
      res.error = diff[ErrWidth-1:0];
      return res;
   endfunction

   // clamp a length to 1..8192 and return length - 1
   function automatic logic [CntWidth-1:0] last_pos(logic [LenWidth-1:0] len);
      logic [LenWidth-1:0] m1;
      if (len == '0) begin
         m1 = '0;
      end else if (len > LenMax) begin
         m1 = LenMax - 14'd1;
      end else begin
         m1 = len - 14'd1;
      end
      return m1[CntWidth-1:0];
   endfunction

endpackage

[rtl/rgb332_row_error_diffusion_top.sv]
`timescale 1ns / 1ps
// a pixel accepted at one edge shows its index at rsp_ the cycle after
// throughput: one pixel per cycle unless stalled, one add-clamp-subtract pass per channel
// the result register frees as it is taken, so a word may enter while one is waiting
// reset (synchronous, active high): errors and counters to zero, line_width 640,
// line_count 480, output register empty
module rgb332_row_error_diffusion_top (
   input  logic                            clock,
   input  logic                            reset,
   // pixel input stream
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [23:0]                     req_tdata,   // blue[7:0], green[15:8], red[23:16]
   // palette index output stream
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [7:0]                      rsp_tdata,   // palette_index[7:0]
   output logic                            rsp_tlast,   // end_of_row
   output logic                            rsp_tuser,   // end_of_image
   // configuration writes
   input  logic                            csr_we,
   input  logic [1:0]                      csr_index,
   input  logic [rgbrd_pkg::LenWidth-1:0]  csr_wdata
);
   import rgbrd_pkg::*;

   // configuration registers
   logic [LenWidth-1:0] line_width_ff, line_count_ff;

   // dither state
   logic [ErrWidth-1:0] red_err_ff, green_err_ff, blue_err_ff;
   logic [ErrWidth-1:0] red_err_in, green_err_in, blue_err_in;
   logic [CntWidth-1:0] col_ff, col_in, row_ff, row_in;

   // output register
   logic                rsp_valid_ff, rsp_valid_in;
   logic [7:0]          rsp_data_ff, rsp_data_in;
   logic                rsp_last_ff, rsp_last_in;
   logic                rsp_user_ff, rsp_user_in;

   logic                accept;
   logic                eor, eoi;
   chan_type            q_red, q_green, q_blue;

   // take a word whenever the output slot is empty or drains this cycle
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;

   // quantize each channel against its running error
   always_comb begin
      q_blue  = quant_rb(blue_err_ff,  req_tdata[7:0]);
      q_green = quant_g (green_err_ff, req_tdata[15:8]);
      q_red   = quant_rb(red_err_ff,   req_tdata[23:16]);
   end

   // a counter at or past the end closes the row or image (covers a shrunk length)
   assign eor = col_ff >= last_pos(line_width_ff);
   assign eoi = eor && (row_ff >= last_pos(line_count_ff));

   always_comb begin
      red_err_in   = red_err_ff;
      green_err_in = green_err_ff;
      blue_err_in  = blue_err_ff;
      col_in       = col_ff;
      row_in       = row_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_user_in  = rsp_user_ff;
      if (accept) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = {q_red.level, q_green.level[1:0], q_blue.level};
         rsp_last_in  = eor;
         rsp_user_in  = eoi;
         if (eor) begin
            // errors restart at every row
            red_err_in   = '0;
            green_err_in = '0;
            blue_err_in  = '0;
            col_in       = '0;
            row_in       = eoi ? '0 : row_ff + 13'd1;
         end else begin
            red_err_in   = q_red.error;
            green_err_in = q_green.error;
            blue_err_in  = q_blue.error;
            col_in       = col_ff + 13'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         line_width_ff <= 14'd640;
         line_count_ff <= 14'd480;
         red_err_ff    <= '0;
         green_err_ff  <= '0;
         blue_err_ff   <= '0;
         col_ff        <= '0;
         row_ff        <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         // writes to indexes beyond the list fall through
         if (csr_we) begin
            case (csr_index)
               CSR_LINE_WIDTH: line_width_ff <= csr_wdata;
               CSR_LINE_COUNT: line_count_ff <= csr_wdata;
               default: ;
            endcase
         end
         red_err_ff   <= red_err_in;
         green_err_ff <= green_err_in;
         blue_err_ff  <= blue_err_in;
         col_ff       <= col_in;
         row_ff       <= row_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload, no reset needed
   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
      rsp_last_ff <= rsp_last_in;
      rsp_user_ff <= rsp_user_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tuser  = rsp_user_ff;

   // end of image only ever comes with end of row
   a_eoi_in_eor: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_user_ff |-> rsp_last_ff)
      else $error("end_of_image without end_of_row");

   // a closed row leaves clean errors and column zero
   a_row_clear: assert property (@(posedge clock) disable iff (reset)
      accept && eor |=> (red_err_ff == '0) && (green_err_ff == '0) && (blue_err_ff == '0)
                        && (col_ff == '0))
      else $error("row state not cleared");

   // an accepted word always lands in the output register
   a_accept_out: assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_valid_ff)
      else $error("accepted word lost");

   // state moves only on an accepted word
   a_state_hold: assert property (@(posedge clock) disable iff (reset)
      !accept |=> $stable(col_ff) && $stable(row_ff) && $stable(red_err_ff))
      else $error("state changed without a word");

endmodule

[verif/tb_rgb332_row_error_diffusion_top.sv]
`timescale 1ns / 1ps

module tb_rgb332_row_error_diffusion_top;
   import rgbrd_pkg::*;

   // register slots past the two real ones, the block must ignore writes there
   localparam logic [1:0] CSR_SPARE_LO = 2'd2;
   localparam logic [1:0] CSR_SPARE_HI = 2'd3;

   // one expected output word
   typedef struct packed {
      logic [7:0] index;
      logic       row_end;
      logic       image_end;
   } dither_word_type;

   // level and leftover error of one channel after quantizing
   typedef struct packed {
      logic [2:0]          level;
      logic [ErrWidth-1:0] error;
   } chan_quant_type;

   // predictor of the ditherer plus the queue of palette indexes still owed
   class dither_board;
      logic [LenWidth-1:0] width_reg;
      logic [LenWidth-1:0] count_reg;
      logic [ErrWidth-1:0] err_b, err_g, err_r;
      logic [CntWidth-1:0] col, row;
      dither_word_type     pending_idx[$];
      int                  pixels_noted, indexes_checked, rows_ended, images_ended;
      int                  mismatches;

      function new();
         width_reg = 14'd640;
         count_reg = 14'd480;
         err_b = '0;
         err_g = '0;
         err_r = '0;
         col = '0;
         row = '0;
      endfunction

      function void write_reg(logic [1:0] idx, logic [LenWidth-1:0] value);
         if (idx == CSR_LINE_WIDTH) begin
            width_reg = value;
         end else if (idx == CSR_LINE_COUNT) begin
            count_reg = value;
         end
      endfunction

      // zero acts as 1, anything past 8192 acts as 8192
      function int clamp_len(logic [LenWidth-1:0] v);
         if (v == '0) return 1;
         if (v > 14'd8192) return 8192;
         return int'(v);
      endfunction

      function chan_quant_type quantize(logic [ErrWidth-1:0] err, logic [7:0] sample,
                                        bit two_bit);
         int             acc;
         int             lvl;
         int             expd;
         int             diff;
         chan_quant_type res;
         acc = $signed(err);
         acc = acc + int'(sample);
         if (acc < 0) begin
            lvl = 0;
         end else if (acc > 255) begin
            lvl = two_bit ? 3 : 7;
         end else begin
            lvl = two_bit ? (acc >> 6) : (acc >> 5);
         end
         if (two_bit) begin
            expd = lvl * 85;
         end else begin
            expd = (lvl << 5) | (lvl << 2) | (lvl >> 1);
         end
         diff = acc - expd;
         res.level = lvl[2:0];
         res.error = diff[ErrWidth-1:0];
         return res;
      endfunction

      function void note_pixel(logic [7:0] b, logic [7:0] g, logic [7:0] r);
         chan_quant_type  qb, qg, qr;
         dither_word_type word;
         qb = quantize(err_b, b, 1'b0);
         qg = quantize(err_g, g, 1'b1);
         qr = quantize(err_r, r, 1'b0);
         err_b = qb.error;
         err_g = qg.error;
         err_r = qr.error;
         word.index = {qr.level, qg.level[1:0], qb.level};
         // a counter already past the end closes the row or image at once
         word.row_end = int'(col) >= clamp_len(width_reg) - 1;
         word.image_end = word.row_end && (int'(row) >= clamp_len(count_reg) - 1);
         pending_idx.push_back(word);
         pixels_noted++;
         if (word.row_end) begin
            rows_ended++;
            col = '0;
            err_b = '0;
            err_g = '0;
            err_r = '0;
            if (word.image_end) begin
               images_ended++;
               row = '0;
            end else begin
               row = row + 1'b1;
            end
         end else begin
            col = col + 1'b1;
         end
      endfunction

      function void check_index(logic [7:0] index, logic row_end, logic image_end);
         dither_word_type want;
         if (pending_idx.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) begin
               $display("%0t: index %02h eor %0b eoi %0b arrived with no pixel pending",
                        $time, index, row_end, image_end);
            end
            return;
         end
         want = pending_idx.pop_front();
         indexes_checked++;
         if (want.index !== index || want.row_end !== row_end ||
             want.image_end !== image_end) begin
            mismatches++;
            if (mismatches <= 10) begin
               $display("%0t: word %0d expected index %02h eor %0b eoi %0b, got %02h %0b %0b",
                        $time, indexes_checked, want.index, want.row_end, want.image_end,
                        index, row_end, image_end);
            end
         end
      endfunction
   endclass

   logic                clock = 1'b0;
   logic                reset;
   logic                req_tvalid;
   logic                req_tready;
   logic [23:0]         req_tdata;   // blue[7:0], green[15:8], red[23:16]
   logic                rsp_tvalid;
   logic                rsp_tready;
   logic [7:0]          rsp_tdata;   // palette_index[7:0]
   logic                rsp_tlast;   // end_of_row
   logic                rsp_tuser;   // end_of_image
   logic                csr_we;
   logic [1:0]          csr_index;
   logic [LenWidth-1:0] csr_wdata;

   dither_board board;
   // when set neither side idles, gives one long back-to-back stretch
   bit                  steady = 1'b0;
   logic [23:0]         last_px = '0;
   int                  geometries = 0;

   rgb332_row_error_diffusion_top dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always #2 clock = ~clock;

   // result side: values seen right after the edge are the ones the edge sampled,
   // since every flop and every testbench input updates through nonblocking assignments
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         board.check_index(rsp_tdata, rsp_tlast, rsp_tuser);
      end
      // back-pressure about 31 percent of the time
      rsp_tready <= steady || ($urandom_range(99) >= 31);
   end

   // samples near the quantizer thresholds and both rails
   function automatic logic [7:0] corner_sample();
      case ($urandom_range(9))
         0: return 8'd0;
         1: return 8'd255;
         2: return 8'd31;
         3: return 8'd32;
         4: return 8'd35;
         5: return 8'd63;
         6: return 8'd64;
         7: return 8'd84;
         8: return 8'd85;
         default: return 8'd224;
      endcase
   endfunction

   // mix of noise, threshold values and smooth image-like gradients
   function automatic logic [23:0] next_pixel();
      logic [23:0] px;
      int          c;
      case ($urandom_range(9))
         0, 1, 2, 3: px = 24'($urandom);
         4: px = {($urandom_range(1) ? 8'hff : 8'h00), ($urandom_range(1) ? 8'hff : 8'h00),
                  ($urandom_range(1) ? 8'hff : 8'h00)};
         5, 6: px = {corner_sample(), corner_sample(), corner_sample()};
         default: begin
            for (int k = 0; k < 3; k++) begin
               c = int'(last_px[8*k +: 8]) + int'($urandom_range(16)) - 8;
               if (c < 0) c = 0;
               if (c > 255) c = 255;
               px[8*k +: 8] = c[7:0];
            end
         end
      endcase
      return px;
   endfunction

   // offer one word, idling first at random, and return once it is taken
   task automatic send_pixel(input logic [23:0] px);
      while (!steady && $urandom_range(99) < 31) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= px;
      do @(posedge clock); while (!req_tready);
      board.note_pixel(px[7:0], px[15:8], px[23:16]);
      last_px = px;
   endtask

   task automatic run_pixels(input int count);
      repeat (count) send_pixel(next_pixel());
      req_tvalid <= 1'b0;
   endtask

   // every word back, then let the output register drain
   task automatic settle();
      while (board.pending_idx.size() != 0) @(posedge clock);
      repeat (3) @(posedge clock);
   endtask

   // rewrite both lengths while idle, now and then poke an unused slot too
   task automatic set_geometry(input logic [LenWidth-1:0] w, input logic [LenWidth-1:0] h);
      logic [LenWidth-1:0] junk;
      logic [1:0]          spare;
      csr_we    <= 1'b1;
      csr_index <= CSR_LINE_WIDTH;
      csr_wdata <= w;
      @(posedge clock);
      board.write_reg(CSR_LINE_WIDTH, w);
      csr_index <= CSR_LINE_COUNT;
      csr_wdata <= h;
      @(posedge clock);
      board.write_reg(CSR_LINE_COUNT, h);
      if ($urandom_range(2) == 0) begin
         junk  = 14'($urandom_range(3));
         spare = $urandom_range(1) ? CSR_SPARE_HI : CSR_SPARE_LO;
         csr_index <= spare;
         csr_wdata <= junk;
         @(posedge clock);
         board.write_reg(spare, junk);
      end
      csr_we <= 1'b0;
      @(posedge clock);
      geometries++;
   endtask

   // directed words, {red, green, blue}
   localparam logic [23:0] DirectedPx[18] = '{
      24'h000000, 24'hffffff,
      24'h1f3f1f,   // large positive errors on every channel
      24'hffffff,   // sum above 255 picks the top level
      24'h235423,   // error of -7 on red and blue, -23 on green
      24'h000000,   // sum below 0 picks level 0
      24'h808080, 24'haa55aa, 24'h55aa55,
      24'hff0000, 24'h00ff00, 24'h0000ff,
      24'h010101, 24'hfefefe, 24'h204020, 24'h245524, 24'he0c0e0, 24'hdfbfdf
   };

   // fixed geometries: degenerate, oversized, and shrinks below the live counters
   localparam logic [LenWidth-1:0] FixedWidth[6] = '{14'd0, 14'd16383, 14'd3, 14'd1,
                                                     14'd1, 14'd8192};
   localparam logic [LenWidth-1:0] FixedCount[6] = '{14'd0, 14'd1, 14'd2, 14'd16383,
                                                     14'd2, 14'd8192};
   localparam int                  FixedItems[6] = '{40, 60, 45, 50, 20, 40};

   initial begin
      logic [LenWidth-1:0] w, h;
      board = new();
      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata  <= '0;
      rsp_tready <= 1'b0;
      csr_we     <= 1'b0;
      csr_index  <= CSR_LINE_WIDTH;
      csr_wdata  <= '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset geometry 640 x 480: directed corners, then some noise
      foreach (DirectedPx[i]) send_pixel(DirectedPx[i]);
      run_pixels(40);
      settle();

      for (int i = 0; i < 6; i++) begin
         set_geometry(FixedWidth[i], FixedCount[i]);
         run_pixels(FixedItems[i]);
         settle();
      end

      // long back-to-back stretch on a small frame
      set_geometry(14'd4, 14'd3);
      steady <= 1'b1;
      run_pixels(300);
      settle();
      steady <= 1'b0;

      while (board.pixels_noted < 1350) begin
         case ($urandom_range(7))
            0: w = 14'd0;
            1: w = 14'd16383;
            2: w = 14'($urandom_range(16383));
            default: w = 14'($urandom_range(1, 24));
         endcase
         h = ($urandom_range(5) == 0) ? 14'($urandom_range(16383)) : 14'($urandom_range(1, 6));
         set_geometry(w, h);
         run_pixels($urandom_range(80, 160));
         settle();
      end

      if (board.pending_idx.size() != 0) begin
         board.mismatches += board.pending_idx.size();
         $display("%0d palette indexes never arrived", board.pending_idx.size());
      end
      $display("covered %0d pixels over %0d geometries, %0d row ends and %0d image ends",
               board.pixels_noted, geometries, board.rows_ended, board.images_ended);
      $display("%0d words checked, %0d mismatches", board.indexes_checked, board.mismatches);
      if (board.mismatches == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

   // watchdog, far beyond the slowest legal run
   initial begin
      #2_000_000;
      $display("timeout with %0d words outstanding", board.pending_idx.size());
      $display("TEST FAILED");
      $finish;
   end

endmodule
